// ----- rtl/mngk_pkg.sv -----
// Package for the MIDI note to gamepad key mapper.
// Shared constants, the queued beat type and the note and partner lookups. No dependencies.
`timescale 1ns / 1ps
package mngk_pkg;
    localparam int NumKeys  = 15;
    localparam int KeyW     = 4;
    localparam int HoldW    = 10;
    localparam logic [HoldW-1:0] HoldCap = 10'd1023;
    localparam logic [7:0] HoldReset = 8'd8;
    localparam logic [3:0] CmdNoteOn  = 4'h9;
    localparam logic [3:0] CmdNoteOff = 4'h8;
    localparam logic [3:0] CmdCtrl    = 4'hB;
    localparam logic [6:0] CcSoundOff = 7'h78;
    localparam logic [6:0] CcResetAll = 7'h79;
    localparam logic [6:0] CcNotesOff = 7'h7B;
    localparam logic [7:0] StickCentre = 8'd128;
    localparam logic [7:0] FullScale   = 8'd255;
    localparam logic [KeyW-1:0] NoPartner = 4'hF;

    // Pending command held against each key.
    localparam logic [1:0] KeyNone = 2'd0;
    localparam logic [1:0] KeyOff  = 2'd1;
    localparam logic [1:0] KeyOn   = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_OFF   = 2'd1,
        OP_ON    = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [KeyW-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic            hit;
        logic [KeyW-1:0] key;
    } t_lookup;

    function automatic t_lookup note_lookup(input logic [6:0] note);
        t_lookup r;
        r.hit = 1'b1;
        case (note)
            7'd60: r.key = 4'd0;
            7'd62: r.key = 4'd1;
            7'd64: r.key = 4'd2;
            7'd65: r.key = 4'd3;
            7'd67: r.key = 4'd4;
            7'd69: r.key = 4'd5;
            7'd71: r.key = 4'd6;
            7'd72: r.key = 4'd7;
            7'd74: r.key = 4'd8;
            7'd76: r.key = 4'd9;
            7'd77: r.key = 4'd10;
            7'd79: r.key = 4'd11;
            7'd81: r.key = 4'd12;
            7'd83: r.key = 4'd13;
            7'd84: r.key = 4'd14;
            default: begin
                r.hit = 1'b0;
                r.key = 4'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [KeyW-1:0] key_partner(input logic [KeyW-1:0] k);
        case (k)
            4'd2:  return 4'd6;
            4'd6:  return 4'd2;
            4'd4:  return 4'd8;
            4'd8:  return 4'd4;
            4'd12: return 4'd14;
            4'd14: return 4'd12;
            default: return NoPartner;
        endcase
    endfunction
endpackage

// ----- rtl/midi_note_to_gamepad_keys.sv -----
// Top level of the MIDI note to gamepad key mapper: register port, front, back.
// Depends on mngk_pkg, mngk_front and mngk_back.
//   channel  handshake                 payload
//   input    i_valid / o_stall         mode, status_byte, note_number, velocity
//   output   o_valid / i_stall         frame_seq .. right_trigger
//   config   APB psel/penable/pwrite   hold_ticks at address 0
// A MIDI beat is taken and queued; the back end applies it from its idle state.
// On a tick the back end walks the 15 keys once for releases and once
// for presses, one key a cycle, then ages the counters.
// A tick with a clear pending skips the release walk.
// The report waits in its register while the output is stalled; the
// front queue keeps taking beats until it is full. Reset is synchronous.
`timescale 1ns / 1ps
module midi_note_to_gamepad_keys (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_velocity,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_frame_seq,
    output logic [13:0] o_buttons,
    output logic [3:0]  o_dpad,
    output logic [7:0]  o_left_x,
    output logic [7:0]  o_left_y,
    output logic [7:0]  o_right_x,
    output logic [7:0]  o_right_y,
    output logic [7:0]  o_left_trigger,
    output logic [7:0]  o_right_trigger
);
    import mngk_pkg::*;

    logic [7:0] r_hold_ticks;
    logic       q_valid, q_pop;
    t_cmd       q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, r_hold_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HoldReset;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_hold_ticks <= pwdata[7:0];
        end
    end

    mngk_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_status_byte,
        .i_note_number, .i_velocity,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd)
    );

    mngk_back u_back (
        .i_clk, .i_rst_n, .i_hold_ticks(r_hold_ticks),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_cmd(q_cmd),
        .o_valid, .i_stall, .o_frame_seq, .o_buttons, .o_dpad, .o_left_x,
        .o_left_y, .o_right_x, .o_right_y, .o_left_trigger, .o_right_trigger
    );
endmodule

// ----- rtl/mngk_front.sv -----
// Front end: accepts input beats, decodes MIDI messages into queued commands.
// Depends on mngk_pkg.
`timescale 1ns / 1ps
module mngk_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_mode,
    input  logic [7:0]     i_status_byte,
    input  logic [6:0]     i_note_number,
    input  logic [6:0]     i_velocity,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output mngk_pkg::t_cmd o_q_cmd
);
    import mngk_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW  = 2;

    t_cmd          r_mem [Depth];
    logic [PtrW:0] r_wr, r_rd;
    t_lookup       lk;
    t_cmd          dec;
    logic          dec_ok, full, push;

    always_comb begin
        lk = note_lookup(i_note_number);
        dec.key = lk.key;
        dec.op  = OP_TICK;
        dec_ok  = 1'b0;
        if (i_mode) begin
            dec_ok = 1'b1;
        end else if (i_status_byte[7:4] == CmdNoteOn && i_velocity != 7'd0) begin
            dec.op = OP_ON;
            dec_ok = lk.hit;
        end else if (i_status_byte[7:4] == CmdNoteOn || i_status_byte[7:4] == CmdNoteOff) begin
            dec.op = OP_OFF;
            dec_ok = lk.hit;
        end else if (i_status_byte[7:4] == CmdCtrl && (i_note_number == CcSoundOff ||
                     i_note_number == CcResetAll || i_note_number == CcNotesOff)) begin
            dec.op = OP_CLEAR;
            dec_ok = 1'b1;
        end
    end

    assign full      = (r_wr[PtrW] != r_rd[PtrW]) && (r_wr[PtrW-1:0] == r_rd[PtrW-1:0]);
    assign o_stall   = full;
    assign push      = i_valid && !full && dec_ok;
    assign o_q_valid = r_wr != r_rd;
    assign o_q_cmd   = r_mem[r_rd[PtrW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (i_q_pop && o_q_valid) r_rd <= r_rd + 1'b1;
        end
        if (push) r_mem[r_wr[PtrW-1:0]] <= dec;
    end
endmodule

// ----- rtl/mngk_back.sv -----
// Back end: key state, tick sequencer walking the keys, report register.
// Depends on mngk_pkg.
`timescale 1ns / 1ps
module mngk_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_hold_ticks,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  mngk_pkg::t_cmd i_q_cmd,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [3:0]     o_frame_seq,
    output logic [13:0]    o_buttons,
    output logic [3:0]     o_dpad,
    output logic [7:0]     o_left_x,
    output logic [7:0]     o_left_y,
    output logic [7:0]     o_right_x,
    output logic [7:0]     o_right_y,
    output logic [7:0]     o_left_trigger,
    output logic [7:0]     o_right_trigger
);
    import mngk_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE, S_REL, S_PRESS, S_AGE
    } t_state;

    t_state           r_state;
    logic [KeyW-1:0]  r_k;
    logic [1:0]       r_cmd  [NumKeys];
    logic [7:0]       r_lock [NumKeys];
    logic [HoldW-1:0] r_hold [NumKeys];
    logic             r_clear;
    logic [13:0]      r_btn;
    logic [3:0]       r_dp;
    logic [7:0]       r_lx, r_rx, r_tl, r_tr;
    logic [3:0]       r_fc;

    logic [KeyW-1:0]  part;
    logic [HoldW-1:0] ht, hk, hp;
    logic [7:0]       lk;
    logic             start;

    assign ht      = {2'b00, i_hold_ticks};
    assign part    = key_partner(r_k);
    assign hk      = r_hold[r_k];
    assign lk      = r_lock[r_k];
    assign hp      = (part == NoPartner) ? '0 : r_hold[part];
    assign start   = i_q_valid && r_state == S_IDLE && !(o_valid && i_stall);
    assign o_q_pop = start;

    always_ff @(posedge i_clk) begin
        logic [13:0] b;
        logic [3:0]  d;
        logic [7:0]  lx, rx, tl, tr;
        logic        go;
        logic        on;
        logic [KeyW-1:0] dk;
        b = r_btn; d = r_dp; lx = r_lx; rx = r_rx; tl = r_tl; tr = r_tr;
        go = 1'b0; on = 1'b0; dk = r_k;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_clear <= 1'b0;
            r_btn <= '0; r_dp <= '0; r_lx <= StickCentre; r_rx <= StickCentre;
            r_tl <= '0; r_tr <= '0; r_fc <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < NumKeys; i++) begin
                r_cmd[i] <= KeyNone; r_lock[i] <= '0; r_hold[i] <= '0;
            end
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (start) begin
                    case (i_q_cmd.op)
                        OP_ON:    r_cmd[i_q_cmd.key] <= KeyOn;
                        OP_OFF:   r_cmd[i_q_cmd.key] <= KeyOff;
                        OP_CLEAR: r_clear <= 1'b1;
                        default: begin
                            r_k <= '0;
                            if (r_clear) begin
                                // Nothing is left to release after a clear.
                                r_clear <= 1'b0;
                                b = '0; d = '0; lx = StickCentre; rx = StickCentre;
                                tl = '0; tr = '0;
                                for (int i = 0; i < NumKeys; i++) begin
                                    r_cmd[i] <= KeyNone; r_lock[i] <= '0; r_hold[i] <= '0;
                                end
                                r_state <= S_PRESS;
                            end else begin
                                r_state <= S_REL;
                            end
                        end
                    endcase
                end
                S_REL: begin
                    if (r_cmd[r_k] == KeyOff) begin
                        r_cmd[r_k] <= KeyNone;
                        if (hk != '0) begin
                            r_lock[r_k] <= i_hold_ticks; r_hold[r_k] <= '0;
                            go = 1'b1;
                        end
                    end
                    r_k <= (r_k == KeyW'(NumKeys - 1)) ? '0 : r_k + 1'b1;
                    if (r_k == KeyW'(NumKeys - 1)) r_state <= S_PRESS;
                end
                S_PRESS: begin
                    if (r_cmd[r_k] == KeyOn && lk == '0) begin
                        if (hk != '0) begin
                            if (hk >= ht) begin
                                r_lock[r_k] <= i_hold_ticks; r_hold[r_k] <= '0;
                                go = 1'b1;
                            end
                        end else if (!(part != NoPartner && hp != '0 && hp < ht)) begin
                            // A partner held long enough is released first.
                            if (part != NoPartner && hp >= ht) begin
                                r_lock[part] <= i_hold_ticks; r_hold[part] <= '0;
                                dk = part;
                                case (dk)
                                    4'd2: d[1] = 1'b0;
                                    4'd4: d[2] = 1'b0;
                                    4'd6: d[0] = 1'b0;
                                    4'd8: d[3] = 1'b0;
                                    default: lx = StickCentre;
                                endcase
                                dk = r_k;
                            end
                            go = 1'b1; on = 1'b1;
                            r_cmd[r_k] <= KeyNone; r_lock[r_k] <= '0; r_hold[r_k] <= 10'd1;
                        end
                    end
                    r_k <= (r_k == KeyW'(NumKeys - 1)) ? '0 : r_k + 1'b1;
                    if (r_k == KeyW'(NumKeys - 1)) r_state <= S_AGE;
                end
                S_AGE: begin
                    for (int i = 0; i < NumKeys; i++) begin
                        if (r_lock[i] != '0) r_lock[i] <= r_lock[i] - 1'b1;
                        if (r_hold[i] != '0 && r_hold[i] < HoldCap)
                            r_hold[i] <= r_hold[i] + 1'b1;
                    end
                    o_valid         <= 1'b1;
                    o_frame_seq     <= r_fc;
                    r_fc            <= r_fc + 1'b1;
                    o_buttons       <= r_btn;
                    o_dpad          <= r_dp;
                    o_left_x        <= r_lx;
                    o_left_y        <= StickCentre;
                    o_right_x       <= r_rx;
                    o_right_y       <= StickCentre;
                    o_left_trigger  <= r_tl;
                    o_right_trigger <= r_tr;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (go) begin
                case (dk)
                    4'd0:  tl = on ? FullScale : 8'd0;
                    4'd1:  tr = on ? FullScale : 8'd0;
                    4'd2:  if (!on) d[1] = 1'b0; else if (!d[0]) d[1] = 1'b1;
                    4'd3:  b[0] = on;
                    4'd4:  if (!on) d[2] = 1'b0; else if (!d[3]) d[2] = 1'b1;
                    4'd5:  b[2] = on;
                    4'd6:  if (!on) d[0] = 1'b0; else if (!d[1]) d[0] = 1'b1;
                    4'd7:  b[3] = on;
                    4'd8:  if (!on) d[3] = 1'b0; else if (!d[2]) d[3] = 1'b1;
                    4'd9:  b[1] = on;
                    4'd10: b[4] = on;
                    4'd11: b[5] = on;
                    4'd12: if (!on) lx = StickCentre; else if (lx == StickCentre) lx = 8'd0;
                    4'd13: rx = on ? 8'd0 : StickCentre;
                    4'd14: if (!on) lx = StickCentre;
                           else if (lx == StickCentre) lx = FullScale;
                    default: ;
                endcase
            end
            r_btn <= b; r_dp <= d; r_lx <= lx; r_rx <= rx; r_tl <= tl; r_tr <= tr;
        end
    end
endmodule

// ----- test/midi_note_to_gamepad_keys_checker.sv -----
// Checker for the MIDI note to gamepad key mapper: watches both channels and the register port,
// predicts every report and compares it field by field. Depends on mngk_pkg.
`timescale 1ns / 1ps
module midi_note_to_gamepad_keys_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_velocity,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [3:0]  o_frame_seq,
    input  logic [13:0] o_buttons,
    input  logic [3:0]  o_dpad,
    input  logic [7:0]  o_left_x,
    input  logic [7:0]  o_left_y,
    input  logic [7:0]  o_right_x,
    input  logic [7:0]  o_right_y,
    input  logic [7:0]  o_left_trigger,
    input  logic [7:0]  o_right_trigger,
    output int          o_fail_count,
    output int          o_pending
);
    import mngk_pkg::*;

    localparam logic [1:0] PendNone = 2'd0;
    localparam logic [1:0] PendOff  = 2'd1;
    localparam logic [1:0] PendOn   = 2'd2;

    typedef struct packed {
        logic [3:0]  seq;
        logic [13:0] buttons;
        logic [3:0]  dpad;
        logic [7:0]  lx;
        logic [7:0]  rx;
        logic [7:0]  lt;
        logic [7:0]  rt;
    } t_report;

    t_report     report_q[$];
    logic [7:0]  min_hold;
    logic [1:0]  pend_cmd[NumKeys];
    logic [7:0]  lockout[NumKeys];
    logic [9:0]  held[NumKeys];
    bit          clear_req;
    logic [13:0] btn;
    logic [3:0]  dp;
    logic [7:0]  lx, rx, lt, rt;
    logic [3:0]  seq;
    int          fails;

    function automatic int key_of_note(input logic [6:0] note);
        case (note)
            7'd60: return 0;  7'd62: return 1;  7'd64: return 2;  7'd65: return 3;
            7'd67: return 4;  7'd69: return 5;  7'd71: return 6;  7'd72: return 7;
            7'd74: return 8;  7'd76: return 9;  7'd77: return 10; 7'd79: return 11;
            7'd81: return 12; 7'd83: return 13; 7'd84: return 14;
            default: return -1;
        endcase
    endfunction

    function automatic int opposite_key(input int k);
        case (k)
            2: return 6;   6: return 2;
            4: return 8;   8: return 4;
            12: return 14; 14: return 12;
            default: return -1;
        endcase
    endfunction

    function void clear_outputs();
        btn = '0;
        dp = '0;
        lx = StickCentre;
        rx = StickCentre;
        lt = '0;
        rt = '0;
    endfunction

    function void set_key_output(input int k, input bit on);
        case (k)
            0: lt = on ? FullScale : 8'd0;
            1: rt = on ? FullScale : 8'd0;
            2: if (!on) dp[1] = 1'b0; else if (!dp[0]) dp[1] = 1'b1;
            3: btn[0] = on;
            4: if (!on) dp[2] = 1'b0; else if (!dp[3]) dp[2] = 1'b1;
            5: btn[2] = on;
            6: if (!on) dp[0] = 1'b0; else if (!dp[1]) dp[0] = 1'b1;
            7: btn[3] = on;
            8: if (!on) dp[3] = 1'b0; else if (!dp[2]) dp[3] = 1'b1;
            9: btn[1] = on;
            10: btn[4] = on;
            11: btn[5] = on;
            12: if (!on) lx = StickCentre; else if (lx == StickCentre) lx = 8'd0;
            13: rx = on ? 8'd0 : StickCentre;
            14: if (!on) lx = StickCentre; else if (lx == StickCentre) lx = FullScale;
            default: ;
        endcase
    endfunction

    function void let_go(input int k);
        lockout[k] = min_hold;
        held[k] = '0;
        set_key_output(k, 1'b0);
    endfunction

    function void reset_model();
        min_hold = HoldReset;
        for (int i = 0; i < NumKeys; i++) begin
            pend_cmd[i] = PendNone;
            lockout[i] = '0;
            held[i] = '0;
        end
        clear_req = 1'b0;
        clear_outputs();
        seq = '0;
        report_q.delete();
    endfunction

    // One tick: clear, then releases, then presses, then counter ageing.
    function void run_tick();
        t_report r;
        int p;
        if (clear_req) begin
            clear_req = 1'b0;
            clear_outputs();
            for (int i = 0; i < NumKeys; i++) begin
                pend_cmd[i] = PendNone;
                lockout[i] = '0;
                held[i] = '0;
            end
        end
        for (int i = 0; i < NumKeys; i++) begin
            if (pend_cmd[i] == PendOff) begin
                pend_cmd[i] = PendNone;
                if (held[i] != 0) let_go(i);
            end
        end
        for (int i = 0; i < NumKeys; i++) begin
            if (pend_cmd[i] != PendOn) continue;
            if (lockout[i] != 0) continue;
            if (held[i] != 0) begin
                if (held[i] < min_hold) continue;
                let_go(i);
                continue;
            end
            p = opposite_key(i);
            if (p >= 0) begin
                if (held[p] != 0 && held[p] < min_hold) continue;
                if (held[p] >= min_hold) let_go(p);
            end
            set_key_output(i, 1'b1);
            pend_cmd[i] = PendNone;
            lockout[i] = '0;
            held[i] = 10'd1;
        end
        for (int i = 0; i < NumKeys; i++) begin
            if (lockout[i] != 0) lockout[i]--;
            if (held[i] != 0 && held[i] < HoldCap) held[i]++;
        end
        r.seq = seq;
        r.buttons = btn;
        r.dpad = dp;
        r.lx = lx;
        r.rx = rx;
        r.lt = lt;
        r.rt = rt;
        report_q.push_back(r);
        seq++;
    endfunction

    function void take_beat();
        int k;
        if (i_mode) begin
            run_tick();
            return;
        end
        k = key_of_note(i_note_number);
        if (i_status_byte[7:4] == CmdNoteOn && i_velocity != 0) begin
            if (k >= 0) pend_cmd[k] = PendOn;
        end else if (i_status_byte[7:4] == CmdNoteOn || i_status_byte[7:4] == CmdNoteOff) begin
            if (k >= 0) pend_cmd[k] = PendOff;
        end else if (i_status_byte[7:4] == CmdCtrl && (i_note_number == CcSoundOff ||
                     i_note_number == CcResetAll || i_note_number == CcNotesOff)) begin
            clear_req = 1'b1;
        end
    endfunction

    function void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    function void check_report();
        t_report r;
        if (report_q.size() == 0) begin
            $error("report beat with no report predicted");
            fails++;
            return;
        end
        r = report_q.pop_front();
        check_field("frame_seq", r.seq, o_frame_seq);
        check_field("buttons", r.buttons, o_buttons);
        check_field("dpad", r.dpad, o_dpad);
        check_field("left_x", r.lx, o_left_x);
        check_field("left_y", StickCentre, o_left_y);
        check_field("right_x", r.rx, o_right_x);
        check_field("right_y", StickCentre, o_right_y);
        check_field("left_trigger", r.lt, o_left_trigger);
        check_field("right_trigger", r.rt, o_right_trigger);
    endfunction

    initial begin
        fails = 0;
        reset_model();
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 2'd0) min_hold = pwdata[7:0];
            if (i_valid && !o_stall) take_beat();
            if (o_valid && !i_stall) check_report();
        end
        o_fail_count <= fails;
        o_pending <= report_q.size();
    end
endmodule

// ----- test/midi_note_to_gamepad_keys_test.sv -----
// Testbench top for the MIDI note to gamepad key mapper: clock, reset, register writes and beats.
// Depends on mngk_pkg, midi_note_to_gamepad_keys and midi_note_to_gamepad_keys_checker.
`timescale 1ns / 1ps
module midi_note_to_gamepad_keys_test;
    import mngk_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_mode = 1'b0;
    logic [7:0]  i_status_byte = '0;
    logic [6:0]  i_note_number = '0;
    logic [6:0]  i_velocity = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_frame_seq, o_dpad;
    logic [13:0] o_buttons;
    logic [7:0]  o_left_x, o_left_y, o_right_x, o_right_y, o_left_trigger, o_right_trigger;
    int          fail_count, reports_due;
    bit          calm = 1'b0;

    const logic [6:0] key_note[15] = '{7'd60, 7'd62, 7'd64, 7'd65, 7'd67, 7'd69, 7'd71,
                                       7'd72, 7'd74, 7'd76, 7'd77, 7'd79, 7'd81, 7'd83, 7'd84};

    always #1 i_clk = ~i_clk;

    midi_note_to_gamepad_keys uut (.*);

    midi_note_to_gamepad_keys_checker checker_i (
        .*, .o_fail_count(fail_count), .o_pending(reports_due)
    );

    always @(posedge i_clk) i_stall <= !calm && ($urandom_range(99) < 15);

    task automatic send_beat(input logic mode, input logic [7:0] status,
                             input logic [6:0] note, input logic [6:0] vel);
        if (!calm && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_status_byte <= status;
        i_note_number <= note;
        i_velocity <= vel;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic tick();
        send_beat(1'b1, 8'($urandom), 7'($urandom), 7'($urandom));
    endtask

    task automatic key_on(input int k);
        send_beat(1'b0, {CmdNoteOn, 4'($urandom)}, key_note[k], 7'($urandom_range(127, 1)));
    endtask

    task automatic key_off(input int k);
        if ($urandom_range(1))
            send_beat(1'b0, {CmdNoteOff, 4'($urandom)}, key_note[k], 7'($urandom));
        else
            send_beat(1'b0, {CmdNoteOn, 4'($urandom)}, key_note[k], 7'd0);
    endtask

    task automatic random_beat();
        int r;
        int cc;
        r = $urandom_range(99);
        if (r < 40) begin
            tick();
        end else if (r < 75) begin
            key_on($urandom_range(14));
        end else if (r < 88) begin
            key_off($urandom_range(14));
        end else if (r < 91) begin
            cc = $urandom_range(2);
            send_beat(1'b0, {CmdCtrl, 4'($urandom)},
                      cc == 0 ? CcSoundOff : (cc == 1 ? CcResetAll : CcNotesOff),
                      7'($urandom));
        end else begin
            send_beat(1'b0, 8'($urandom), 7'($urandom), 7'($urandom));
        end
    endtask

    // Registers change only once every report is out and the block has gone quiet.
    task automatic write_hold(input logic [7:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (reports_due != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 2'd0;
        pwdata <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin
        logic [7:0] holds[5];
        holds = '{8'd1, 8'd0, 8'd255, 8'd3, 8'($urandom_range(255, 1))};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at the default hold.
        send_beat(1'b0, 8'h9F, 7'd84, 7'd127);
        send_beat(1'b0, 8'h90, 7'd60, 7'd1);
        send_beat(1'b0, 8'h93, 7'd81, 7'd64);
        send_beat(1'b0, 8'h95, 7'd64, 7'd10);
        send_beat(1'b0, 8'h95, 7'd71, 7'd10);
        tick();
        tick();
        send_beat(1'b0, 8'h9A, 7'd60, 7'd50);
        send_beat(1'b0, 8'h80, 7'd84, 7'd0);
        send_beat(1'b0, 8'h90, 7'd62, 7'd0);
        send_beat(1'b0, 8'hFF, 7'd127, 7'd127);
        send_beat(1'b0, 8'h00, 7'd0, 7'd0);
        send_beat(1'b0, 8'h90, 7'd61, 7'd100);
        tick();
        send_beat(1'b0, 8'hB0, 7'h7A, 7'd0);
        repeat (9) tick();
        send_beat(1'b0, 8'hB7, CcSoundOff, 7'd0);
        tick();
        send_beat(1'b0, 8'hBF, CcResetAll, 7'd127);
        send_beat(1'b0, 8'hB1, CcNotesOff, 7'd3);
        send_beat(1'b1, 8'hFF, 7'd127, 7'd127);

        foreach (holds[ph]) begin
            write_hold(holds[ph]);
            calm = (ph == 2);
            repeat (50) random_beat();
            calm = 1'b0;
        end

        // Long hold so that the hold count saturates.
        write_hold(8'd2);
        key_on(1);
        key_on(13);
        repeat (1040) begin
            tick();
            if ($urandom_range(99) < 3) key_on($urandom_range(14));
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (reports_due != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
